>>> hw/rtl/phm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phm_pkg
// Shared types and constants of the pixel histogram with running mode.
// ----------------------------------------------------------------------------
package phm_pkg;

    localparam int unsigned VALUE_BITS_DEF = 12;
    localparam int unsigned COUNT_BITS_DEF = 32;

    localparam int unsigned PIXEL_W = 12;
    localparam int unsigned MODE_CNT_W = 32;
    localparam int unsigned TOTAL_W = 40;
    localparam int unsigned BIN_CNT_W = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REPORT = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

endpackage : phm_pkg
`default_nettype wire

>>> hw/rtl/pixel_histogram_with_mode_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_histogram_with_mode_top
// Pixel histogram in one synchronous RAM with a running mode and total.
//
//  Channel   Handshake               Payload
//  command   start / busy            action, pixel_value
//  result    done (one-cycle strobe) mode_value, mode_count, total_count,
//                                    bin_count
//
//  A command is taken every cycle while busy is low. Each command reads its
//  bin from the RAM in the cycle of the transfer and finishes in the next
//  one; a repeated bin is forwarded around the RAM write. Report and read
//  raise done from done_reg, which loads together with the result registers
//  after the s1 stage. Reset and each clear sweep the RAM one bin a cycle:
//  busy stays high for the whole sweep, and for a clear also while the clear
//  is in the s1 stage. The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
module pixel_histogram_with_mode_top
    import phm_pkg::*;
#(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            action,
    input  wire logic [PIXEL_W-1:0]    pixel_value,
    output logic                       done,
    output logic [PIXEL_W-1:0]         mode_value,
    output logic [MODE_CNT_W-1:0]      mode_count,
    output logic [TOTAL_W-1:0]         total_count,
    output logic [BIN_CNT_W-1:0]       bin_count
);

    localparam int unsigned DEPTH = 1 << VALUE_BITS;
    localparam int unsigned IDX_BITS = (VALUE_BITS < PIXEL_W) ? VALUE_BITS : PIXEL_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] ADDR_LAST = {VALUE_BITS{1'b1}};

    logic [COUNT_BITS-1:0] mem [DEPTH];

    logic                  accept;
    logic [VALUE_BITS-1:0] in_addr;

    logic                  s1_valid_reg;
    action_t               s1_action_reg;
    logic [VALUE_BITS-1:0] s1_addr_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic                  clearing_reg;
    logic [VALUE_BITS-1:0] clr_cnt_reg;

    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    logic [VALUE_BITS-1:0] best_value_reg;
    logic [VALUE_BITS-1:0] best_value_next;
    logic [COUNT_BITS-1:0] best_count_reg;
    logic [COUNT_BITS-1:0] best_count_next;

    logic                  s1_add;
    logic                  s1_clear;
    logic                  s1_emit;
    logic [COUNT_BITS-1:0] new_count;

    logic                  wr_en;
    logic [VALUE_BITS-1:0] wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    logic                  done_reg;
    logic [PIXEL_W-1:0]    mode_value_reg;
    logic [MODE_CNT_W-1:0] mode_count_reg;
    logic [TOTAL_W-1:0]    total_count_reg;
    logic [BIN_CNT_W-1:0]  bin_count_reg;

    assign s1_add   = s1_valid_reg && (s1_action_reg == ACT_ADD);
    assign s1_clear = s1_valid_reg && (s1_action_reg == ACT_CLEAR);
    assign s1_emit  = s1_valid_reg &&
                      ((s1_action_reg == ACT_REPORT) || (s1_action_reg == ACT_READ));

    assign busy    = clearing_reg || s1_clear;
    assign accept  = start && !busy;
    assign in_addr = VALUE_BITS'(pixel_value[IDX_BITS-1:0]);

    assign new_count = (rd_data_reg == COUNT_MAX) ? rd_data_reg
                                                  : rd_data_reg + COUNT_BITS'(1);

    always_comb
    begin
        total_next      = total_reg;
        best_value_next = best_value_reg;
        best_count_next = best_count_reg;
        if (s1_clear)
        begin
            total_next      = '0;
            best_value_next = '0;
            best_count_next = '0;
        end
        else if (s1_add)
        begin
            if (total_reg != TOTAL_MAX)
            begin
                total_next = total_reg + TOTAL_W'(1);
            end
            if ((new_count > best_count_reg) ||
                ((new_count == best_count_reg) && (s1_addr_reg > best_value_reg)))
            begin
                best_count_next = new_count;
                best_value_next = s1_addr_reg;
            end
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = s1_add;
            wr_addr = s1_addr_reg;
            wr_data = new_count;
        end
    end

    // RAM with forwarding of a same-edge write to the read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == in_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[in_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            total_reg      <= '0;
            best_value_reg <= '0;
            best_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= accept;
            total_reg      <= total_next;
            best_value_reg <= best_value_next;
            best_count_reg <= best_count_next;
            done_reg       <= s1_emit;
            if (s1_clear)
            begin
                clearing_reg <= 1'b1;
                clr_cnt_reg  <= '0;
            end
            else if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + VALUE_BITS'(1);
                if (clr_cnt_reg == ADDR_LAST)
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= action_t'(action);
            s1_addr_reg   <= in_addr;
        end
        if (s1_emit)
        begin
            mode_value_reg  <= PIXEL_W'(best_value_reg);
            mode_count_reg  <= MODE_CNT_W'(best_count_reg);
            total_count_reg <= total_reg;
            bin_count_reg   <= (s1_action_reg == ACT_READ) ? BIN_CNT_W'(rd_data_reg) : '0;
        end
    end

    assign done        = done_reg;
    assign mode_value  = mode_value_reg;
    assign mode_count  = mode_count_reg;
    assign total_count = total_count_reg;
    assign bin_count   = bin_count_reg;

    a_fwd_same_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_add && (in_addr == s1_addr_reg)) |=> (rd_data_reg == $past(new_count)))
        else $error("repeated bin not forwarded");

    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        s1_clear |=> (clearing_reg && (total_reg == '0) && (best_count_reg == '0)))
        else $error("clear did not reset state");

    a_sweep_full: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> ($past(clr_cnt_reg) == ADDR_LAST))
        else $error("clear sweep ended early");

    a_empty_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (best_count_reg == '0) |-> (best_value_reg == '0))
        else $error("mode value set on empty histogram");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(s1_emit))
        else $error("result strobe without report or read");

endmodule : pixel_histogram_with_mode_top
`default_nettype wire

>>> test/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Testbench of the pixel histogram with running mode. Commands are sent over
// the start/busy handshake, and a behavioral histogram in the testbench
// predicts every report and read. Each done strobe is checked field by field
// against the oldest predicted result. Directed tests cover the empty
// histogram, extreme pixel values, mode ties and clear. Random phases follow,
// with varying sender idle rates.
// ----------------------------------------------------------------------------
module tb;
    import phm_pkg::*;

    localparam int unsigned BIN_DEPTH   = 1 << PIXEL_W;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned TAIL_CYCLES = 8;

    typedef struct {
        logic [PIXEL_W-1:0]    mode_value;
        logic [MODE_CNT_W-1:0] mode_count;
        logic [TOTAL_W-1:0]    total_count;
        logic [BIN_CNT_W-1:0]  bin_count;
    } hist_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [1:0]            action = ACT_ADD;
    logic [PIXEL_W-1:0]    pixel_value = '0;
    logic                  busy;
    logic                  done;
    logic [PIXEL_W-1:0]    mode_value;
    logic [MODE_CNT_W-1:0] mode_count;
    logic [TOTAL_W-1:0]    total_count;
    logic [BIN_CNT_W-1:0]  bin_count;

    logic [BIN_CNT_W-1:0]  bin_tally [BIN_DEPTH];
    logic [TOTAL_W-1:0]    pixel_sum;
    logic [PIXEL_W-1:0]    top_value;
    logic [MODE_CNT_W-1:0] top_count;
    hist_result_t          expected_reports[$];
    logic [PIXEL_W-1:0]    hot_pixels [6];
    int unsigned           error_count = 0;
    int unsigned           cycle_count = 0;

    pixel_histogram_with_mode_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .pixel_value (pixel_value),
        .done        (done),
        .mode_value  (mode_value),
        .mode_count  (mode_count),
        .total_count (total_count),
        .bin_count   (bin_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < 40)
            $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void hist_clear();
        foreach (bin_tally[i])
            bin_tally[i] = '0;
        pixel_sum = '0;
        top_value = '0;
        top_count = '0;
    endfunction

    function automatic void hist_apply(input action_t act, input logic [PIXEL_W-1:0] pix,
                                       output bit has_result, output hist_result_t res);
        logic [BIN_CNT_W-1:0] c;
        has_result = 1'b0;
        res.mode_value  = top_value;
        res.mode_count  = top_count;
        res.total_count = pixel_sum;
        res.bin_count   = '0;
        case (act)
            ACT_ADD:
            begin
                c = bin_tally[pix];
                if (c != '1)
                begin
                    c++;
                    bin_tally[pix] = c;
                end
                if (pixel_sum != TOTAL_MAX)
                    pixel_sum++;
                if (c > top_count || (c == top_count && pix > top_value))
                begin
                    top_count = c;
                    top_value = pix;
                end
            end
            ACT_REPORT:
                has_result = 1'b1;
            ACT_READ:
            begin
                has_result = 1'b1;
                res.bin_count = bin_tally[pix];
            end
            default:
                hist_clear();
        endcase
    endfunction

    always @(posedge clk)
    begin
        hist_result_t want;
        if (rst_n && done)
        begin
            if (expected_reports.size() == 0)
                report_mismatch("unexpected result", {52'd0, mode_value}, 64'd0);
            else
            begin
                want = expected_reports.pop_front();
                if (mode_value !== want.mode_value)
                    report_mismatch("mode_value", 64'(mode_value), 64'(want.mode_value));
                if (mode_count !== want.mode_count)
                    report_mismatch("mode_count", 64'(mode_count), 64'(want.mode_count));
                if (total_count !== want.total_count)
                    report_mismatch("total_count", 64'(total_count),
                                    64'(want.total_count));
                if (bin_count !== want.bin_count)
                    report_mismatch("bin_count", 64'(bin_count), 64'(want.bin_count));
            end
        end
    end

    // hold start until the transfer, then predict
    task automatic send_cmd(input action_t act, input logic [PIXEL_W-1:0] pix,
                            input int unsigned gap);
        bit           has_result;
        hist_result_t res;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        action      <= act;
        pixel_value <= pix;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        hist_apply(act, pix, has_result, res);
        if (has_result)
            expected_reports.push_back(res);
    endtask

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return hot_pixels[$urandom_range(5)];
        if (r < 75)
        begin
            case ($urandom_range(3))
                0: return '0;
                1: return '1;
                2: return {1'b1, {(PIXEL_W-1){1'b0}}};
                default: return {1'b0, {(PIXEL_W-1){1'b1}}};
            endcase
        end
        return PIXEL_W'($urandom_range(BIN_DEPTH - 1));
    endfunction

    function automatic void refresh_hot_pixels();
        foreach (hot_pixels[i])
            hot_pixels[i] = PIXEL_W'($urandom_range(BIN_DEPTH - 1));
        if ($urandom_range(1))
            hot_pixels[0] = '0;
        if ($urandom_range(1))
            hot_pixels[1] = '1;
    endfunction

    task automatic test_empty();
        send_cmd(ACT_REPORT, '0, 0);
        send_cmd(ACT_READ, '0, 0);
        send_cmd(ACT_READ, '1, 0);
    endtask

    task automatic test_extremes_and_ties();
        send_cmd(ACT_ADD, '0, 0);
        send_cmd(ACT_ADD, '1, 0);
        send_cmd(ACT_REPORT, '0, 0);
        send_cmd(ACT_ADD, '0, 0);
        send_cmd(ACT_ADD, '1, 0);
        send_cmd(ACT_ADD, '0, 0);
        send_cmd(ACT_ADD, '1, 0);
        send_cmd(ACT_REPORT, '0, 0);
        repeat (3) send_cmd(ACT_ADD, 12'd2048, 0);
        send_cmd(ACT_REPORT, '0, 0);
        send_cmd(ACT_READ, '0, 0);
        send_cmd(ACT_READ, 12'd2048, 0);
    endtask

    task automatic test_clear();
        send_cmd(ACT_CLEAR, 12'd1234, 0);
        send_cmd(ACT_REPORT, '1, 0);
        send_cmd(ACT_READ, '1, 0);
    endtask

    task automatic test_random(input int unsigned idle_pct, input int unsigned count);
        int unsigned r;
        int unsigned gap;
        action_t     act;
        refresh_hot_pixels();
        for (int unsigned n = 0; n < count; n++)
        begin
            r = $urandom_range(999);
            if (r < 15)
                act = ACT_CLEAR;
            else if (r < 135)
                act = ACT_REPORT;
            else if (r < 285)
                act = ACT_READ;
            else
                act = ACT_ADD;
            gap = 0;
            while (idle_pct > 0 && gap < 20 && $urandom_range(99) < idle_pct)
                gap++;
            send_cmd(act, (act == ACT_CLEAR || act == ACT_REPORT) ?
                     PIXEL_W'($urandom_range(BIN_DEPTH - 1)) : pick_pixel(), gap);
            if (act == ACT_CLEAR)
                refresh_hot_pixels();
        end
    endtask

    initial
    begin
        hist_clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_empty();
        test_extremes_and_ties();
        test_clear();
        test_random(0, 620);
        test_random(58, 620);
        test_random(6, 620);
        start <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule : tb
`default_nettype wire
